// ===== rtl/ktpl_pkg.sv =====
// package for the keyed table unit: action and status codes, queue and result types
// no dependencies
package ktpl_pkg;

  typedef enum logic [2:0] {
    ACT_INSERT   = 3'd0,
    ACT_FIND_KEY = 3'd1,
    ACT_FIND_PAR = 3'd2,
    ACT_DEL_KEY  = 3'd3,
    ACT_DEL_CHLD = 3'd4
  } action_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_DUP     = 2'd1,
    ST_FULL    = 2'd2,
    ST_NOMATCH = 2'd3
  } status_t;

  typedef struct packed {
    logic [2:0]  action;
    logic [31:0] key_value;
    logic [31:0] parent_value;
    logic [31:0] info_value;
  } cmd_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] entry_key;
    logic [31:0] entry_parent;
    logic [31:0] entry_info;
    logic [4:0]  removed_count;
    logic        last;
  } res_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_SCAN,
    BK_EMIT,
    BK_DONE
  } bk_state_t;

endpackage

// ===== rtl/ktpl_front.sv =====
// front end: accepts input beats, drops undefined actions, feeds a two-entry queue
// depends on ktpl_pkg
module ktpl_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  output logic                in_tready,
  input  logic [103:0]        in_tdata,
  output logic                q_valid,
  input  logic                q_pop,
  output ktpl_pkg::cmd_t      q_cmd
);
  import ktpl_pkg::*;

  cmd_t       mem_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;
  logic       push, pop;
  cmd_t       c;

  assign c.action       = in_tdata[2:0];
  assign c.key_value    = in_tdata[34:3];
  assign c.parent_value = in_tdata[66:35];
  assign c.info_value   = in_tdata[98:67];

  assign in_tready = (cnt_r != 2'd2);
  assign push = in_tvalid && in_tready && (c.action <= 3'd4);
  assign q_valid = (cnt_r != 2'd0);
  assign pop = q_pop && q_valid;
  assign q_cmd = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= c;
    if (!rst_n) begin
      wp_r <= 1'b0;
      rp_r <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (pop) rp_r <= ~rp_r;
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, pop};
    end
  end
endmodule

// ===== rtl/ktpl_back.sv =====
// back end: scans an entry per cycle, pausing to emit find hits; compacts on delete
// depends on ktpl_pkg
module ktpl_back #(
  parameter int TABLE_DEPTH = 16
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           q_valid,
  output logic           q_pop,
  input  ktpl_pkg::cmd_t q_cmd,
  output logic           res_valid,
  input  logic           res_ready,
  output ktpl_pkg::res_t res
);
  import ktpl_pkg::*;

  localparam int IW = $clog2(TABLE_DEPTH);
  localparam int CW = $clog2(TABLE_DEPTH + 1);

  logic [31:0] key_r [TABLE_DEPTH];
  logic [31:0] par_r [TABLE_DEPTH];
  logic [31:0] inf_r [TABLE_DEPTH];
  logic [CW-1:0] count_r, count_nxt;
  logic [CW-1:0] rd_r, rd_nxt;
  logic [CW-1:0] wr_r, wr_nxt;
  logic          found_r, found_nxt;
  logic          dup_r, dup_nxt;
  bk_state_t     state_r, state_nxt;
  cmd_t          cmd_r, cmd_nxt;
  res_t          res_r, res_nxt;
  logic          res_valid_r, res_valid_nxt;
  logic          pend_r, pend_nxt;
  res_t          pend_res_r, pend_res_nxt;
  logic          mv_en, ins_en;
  logic [IW-1:0] ri, wi, ci;
  logic [31:0]   probe;
  logic          hit, more, ncount_full;
  logic [CW-1:0] gone;
  logic [4:0]    removed;

  assign ri = rd_r[IW-1:0];
  assign wi = wr_r[IW-1:0];
  assign ci = count_r[IW-1:0];
  assign probe = (cmd_r.action == ACT_FIND_PAR || cmd_r.action == ACT_DEL_CHLD)
                 ? par_r[ri] : key_r[ri];
  assign hit = (probe == cmd_r.key_value);
  assign more = (rd_r < count_r);
  assign ncount_full = (count_r == CW'(TABLE_DEPTH));
  assign gone = count_r - wr_r;
  assign removed = (32'(gone) > 32'd31) ? 5'd31 : 5'(gone);
  assign res_valid = res_valid_r;
  assign res = res_r;

  always_comb begin
    state_nxt = state_r;
    count_nxt = count_r;
    rd_nxt = rd_r;
    wr_nxt = wr_r;
    found_nxt = found_r;
    dup_nxt = dup_r;
    cmd_nxt = cmd_r;
    res_nxt = res_r;
    res_valid_nxt = res_valid_r && !res_ready;
    pend_nxt = pend_r;
    pend_res_nxt = pend_res_r;
    q_pop = 1'b0;
    mv_en = 1'b0;
    ins_en = 1'b0;
    // move a held final beat into the output register when it frees
    if (pend_r && pend_res_r.last && !res_valid_nxt) begin
      res_nxt = pend_res_r;
      res_valid_nxt = 1'b1;
      pend_nxt = 1'b0;
    end
    case (state_r)
      BK_IDLE: begin
        if (q_valid) begin
          q_pop = 1'b1;
          cmd_nxt = q_cmd;
          rd_nxt = '0;
          wr_nxt = '0;
          found_nxt = 1'b0;
          dup_nxt = 1'b0;
          state_nxt = BK_SCAN;
        end
      end
      BK_SCAN: begin
        if (!more) begin
          state_nxt = BK_DONE;
        end else begin
          case (cmd_r.action)
            ACT_INSERT: begin
              if (hit) dup_nxt = 1'b1;
              rd_nxt = rd_r + 1'b1;
            end
            ACT_FIND_KEY, ACT_FIND_PAR: begin
              if (hit) state_nxt = BK_EMIT;
              else rd_nxt = rd_r + 1'b1;
            end
            default: begin
              if (!hit) begin
                mv_en = 1'b1;
                wr_nxt = wr_r + 1'b1;
              end
              rd_nxt = rd_r + 1'b1;
            end
          endcase
        end
      end
      BK_EMIT: begin
        // the previous match is not final, send it before holding this one
        if (pend_nxt && !pend_res_r.last && !res_valid_nxt) begin
          res_nxt = pend_res_r;
          res_valid_nxt = 1'b1;
          pend_nxt = 1'b0;
        end
        if (!pend_nxt) begin
          pend_nxt = 1'b1;
          pend_res_nxt.status = ST_OK;
          pend_res_nxt.entry_key = key_r[ri];
          pend_res_nxt.entry_parent = par_r[ri];
          pend_res_nxt.entry_info = inf_r[ri];
          pend_res_nxt.removed_count = '0;
          pend_res_nxt.last = 1'b0;
          found_nxt = 1'b1;
          rd_nxt = rd_r + 1'b1;
          state_nxt = BK_SCAN;
        end
      end
      BK_DONE: begin
        if ((cmd_r.action == ACT_FIND_KEY || cmd_r.action == ACT_FIND_PAR) && found_r) begin
          // the held match is the final one
          pend_res_nxt.last = 1'b1;
          state_nxt = BK_IDLE;
        end else if (!pend_nxt) begin
          pend_nxt = 1'b1;
          pend_res_nxt = '0;
          pend_res_nxt.last = 1'b1;
          case (cmd_r.action)
            ACT_INSERT: begin
              if (dup_r) pend_res_nxt.status = ST_DUP;
              else if (ncount_full) pend_res_nxt.status = ST_FULL;
              else begin
                pend_res_nxt.status = ST_OK;
                ins_en = 1'b1;
                count_nxt = count_r + 1'b1;
              end
            end
            ACT_FIND_KEY, ACT_FIND_PAR: begin
              pend_res_nxt.status = ST_NOMATCH;
            end
            default: begin
              pend_res_nxt.status = (removed != 5'd0) ? ST_OK : ST_NOMATCH;
              pend_res_nxt.removed_count = removed;
              count_nxt = wr_r;
            end
          endcase
          state_nxt = BK_IDLE;
        end
      end
      default: state_nxt = BK_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mv_en) begin
      key_r[wi] <= key_r[ri];
      par_r[wi] <= par_r[ri];
      inf_r[wi] <= inf_r[ri];
    end
    if (ins_en) begin
      key_r[ci] <= cmd_r.key_value;
      par_r[ci] <= cmd_r.parent_value;
      inf_r[ci] <= cmd_r.info_value;
    end
    cmd_r <= cmd_nxt;
    rd_r <= rd_nxt;
    wr_r <= wr_nxt;
    found_r <= found_nxt;
    dup_r <= dup_nxt;
    res_r <= res_nxt;
    pend_res_r <= pend_res_nxt;
    if (!rst_n) begin
      state_r <= BK_IDLE;
      count_r <= '0;
      res_valid_r <= 1'b0;
      pend_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      res_valid_r <= res_valid_nxt;
      pend_r <= pend_nxt;
    end
  end
endmodule

// ===== rtl/keyed_table_with_parent_links_unit.sv =====
// keyed table with parent links: top level joining front queue and back scanner
// depends on ktpl_pkg, ktpl_front, ktpl_back
// the back end scans the whole table for each command and takes the next one only when done
// find matches leave one beat per match; output register plus one holding slot
// reset: rst_n synchronous active low empties the table and the queue
module keyed_table_with_parent_links_unit #(
  parameter int TABLE_DEPTH = 16
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [103:0] in_tdata,   // action, key_value, parent_value, info_value
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [103:0] out_tdata,  // status, entry_key, entry_parent, entry_info, removed_count
  output logic         out_tlast
);
  import ktpl_pkg::*;

  logic q_valid, q_pop;
  cmd_t q_cmd;
  res_t r;

  ktpl_front u_front (
    .clk, .rst_n, .in_tvalid, .in_tready, .in_tdata,
    .q_valid, .q_pop, .q_cmd
  );

  ktpl_back #(.TABLE_DEPTH(TABLE_DEPTH)) u_back (
    .clk, .rst_n, .q_valid, .q_pop, .q_cmd,
    .res_valid(out_tvalid), .res_ready(out_tready), .res(r)
  );

  assign out_tdata = {1'b0, r.removed_count, r.entry_info, r.entry_parent,
                      r.entry_key, r.status};
  assign out_tlast = r.last;
endmodule

// ===== rtl/ktpl_checker.sv =====
// port checker for the keyed table unit, bound to the top level
// depends on keyed_table_with_parent_links_unit ports only
module ktpl_props (
  input logic         clk,
  input logic         rst_n,
  input logic         in_tready,
  input logic         out_tvalid,
  input logic         out_tready,
  input logic [103:0] out_tdata,
  input logic         out_tlast
);
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("output beat dropped");
  a_rst: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("valid after reset");
  a_rst_rdy: assert property (@(posedge clk) !rst_n |=> in_tready)
    else $error("input not ready after reset");
  a_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tlast |-> out_tdata[1:0] == 2'd0)
    else $error("non-final beat not a match");
  a_pad: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !out_tdata[103])
    else $error("pad bit set");
endmodule

bind keyed_table_with_parent_links_unit ktpl_props u_chk (
  .clk, .rst_n, .in_tready, .out_tvalid, .out_tready, .out_tdata, .out_tlast
);
